### sv/hps_pkg.sv
// Shared types, constants and table functions for the heartbeat PWM pattern sequencer.
package hps_pkg;

	// field widths
	localparam int unsigned POT_W    = 10;
	localparam int unsigned DUTY_W   = 10;
	localparam int unsigned BRIGHT_W = 8;
	localparam int unsigned IDX_W    = 5;
	localparam int unsigned STEP_W   = 3;
	localparam int unsigned PAUSE_W  = 8;

	// table depth addressed by the index
	localparam int unsigned WAVE_DEPTH = 32;

	// defaults for the top-level parameters
	localparam int unsigned WAVE_LEN_DEF = 24;
	localparam int unsigned DUTY_TOP_DEF = 999;

	// pause length = PAUSE_BASE + period * PAUSE_SPAN / POT_FULL
	localparam int unsigned PAUSE_BASE = 30;
	localparam int unsigned PAUSE_SPAN = 220;
	localparam int unsigned POT_FULL   = 1023;
	localparam int unsigned BRIGHT_MAX = 255;

	typedef logic [WAVE_DEPTH-1:0][DUTY_W-1:0] duty_lut_t;

	// Heartbeat brightness shape; positions past the listed entries read as zero
	function automatic logic [BRIGHT_W-1:0] wave_entry(input logic [IDX_W-1:0] idx);
		logic [BRIGHT_W-1:0] b;
		case (idx)
			5'd0:    b = 8'd0;
			5'd1:    b = 8'd12;
			5'd2:    b = 8'd45;
			5'd3:    b = 8'd110;
			5'd4:    b = 8'd195;
			5'd5:    b = 8'd252;
			5'd6:    b = 8'd255;
			5'd7:    b = 8'd235;
			5'd8:    b = 8'd190;
			5'd9:    b = 8'd140;
			5'd10:   b = 8'd95;
			5'd11:   b = 8'd70;
			5'd12:   b = 8'd85;
			5'd13:   b = 8'd115;
			5'd14:   b = 8'd148;
			5'd15:   b = 8'd165;
			5'd16:   b = 8'd155;
			5'd17:   b = 8'd130;
			5'd18:   b = 8'd98;
			5'd19:   b = 8'd65;
			5'd20:   b = 8'd35;
			5'd21:   b = 8'd14;
			5'd22:   b = 8'd3;
			default: b = 8'd0;
		endcase
		return b;
	endfunction

	// Duty for every table position, worked out at elaboration; masked to the field
	function automatic duty_lut_t build_duty_lut(input int unsigned top);
		duty_lut_t   lut;
		int unsigned prod;
		for (int unsigned i = 0; i < WAVE_DEPTH; i++) begin
			prod   = int'(wave_entry(IDX_W'(i))) * top;
			lut[i] = DUTY_W'(prod / BRIGHT_MAX);
		end
		return lut;
	endfunction

endpackage

### sv/hps_if.sv
// Handshake channels of the sequencer: tick samples in, LED drive results out.
interface hps_in_if;
	import hps_pkg::*;

	logic               valid;
	logic               ready;
	logic [POT_W-1:0]   period_pot;
	logic [POT_W-1:0]   rate_pot;

	modport source (output valid, output period_pot, output rate_pot, input ready);
	modport sink   (input valid, input period_pot, input rate_pot, output ready);
endinterface

interface hps_out_if;
	import hps_pkg::*;

	logic                valid;
	logic                ready;
	logic [DUTY_W-1:0]   duty;
	logic [BRIGHT_W-1:0] brightness;
	logic                pausing;

	modport source (output valid, output duty, output brightness, output pausing, input ready);
	modport sink   (input valid, input duty, input brightness, input pausing, output ready);
endinterface

### sv/heartbeat_pwm_pattern_sequencer.sv
// Heartbeat PWM pattern sequencer: tick register, state update, result register.
//
//  Channel | Dir | Payload                      | Beat
//  --------+-----+------------------------------+--------------------------
//  tick    | in  | period_pot, rate_pot         | one animation tick
//  led     | out | duty, brightness, pausing    | LED drive after that tick
//
// One tick per clock sustained while led is not stalled; an accepted tick passes the tick
// register, then the state and result registers, before its beat shows on led.
// Latency is set by the tick register and the result register; the state
// update between them is one counter step and a table look-up.
// arst_n clears the index, counters, pause flag, held values and both valid bits.
// A stalled led beat holds; tick stays ready while the result register can move.
module heartbeat_pwm_pattern_sequencer #(
	parameter int unsigned WAVE_LEN = hps_pkg::WAVE_LEN_DEF,
	parameter int unsigned DUTY_TOP = hps_pkg::DUTY_TOP_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	hps_in_if.sink    tick,
	hps_out_if.source led
);
	import hps_pkg::*;

	localparam duty_lut_t DUTY_LUT = build_duty_lut(DUTY_TOP);

	// tick register
	logic             valid_s1;
	logic [POT_W-1:0] period_s1;
	logic [POT_W-1:0] rate_s1;

	// sequencer state
	logic [IDX_W-1:0]    wave_index_q;
	logic                pause_flag_q;
	logic [STEP_W-1:0]   step_count_q;
	logic [PAUSE_W-1:0]  pause_count_q;
	logic [BRIGHT_W-1:0] held_bright_q;
	logic [DUTY_W-1:0]   held_duty_q;

	// result register
	logic                out_valid_q;

	logic advance;

	// next state
	logic [IDX_W-1:0]    wave_index_d;
	logic                pause_flag_d;
	logic [STEP_W-1:0]   step_count_d;
	logic [PAUSE_W-1:0]  pause_count_d;
	logic [BRIGHT_W-1:0] held_bright_d;
	logic [DUTY_W-1:0]   held_duty_d;

	logic [STEP_W-1:0]   divider;
	logic [STEP_W-1:0]   step_inc;
	logic [IDX_W:0]      next_index;
	logic [PAUSE_W-1:0]  pause_inc;
	logic [17:0]         period_prod;
	logic [PAUSE_W-1:0]  quot_est;
	logic [10:0]         rem_est;
	logic [PAUSE_W-1:0]  pause_len;

	// handshake: the tick register moves on whenever the result register can take it
	assign advance    = valid_s1 && (!out_valid_q || led.ready);
	assign tick.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick.ready) begin
			valid_s1 <= tick.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick.valid && tick.ready) begin
			period_s1 <= tick.period_pot;
			rate_s1   <= tick.rate_pot;
		end
	end

	// divider 1..4 from the top two bits of the rate sample
	assign divider = STEP_W'(rate_s1[POT_W-1 -: 2]) + STEP_W'(1);

	// pause length: period*220/1023 by x/1024 estimate plus one correction
	assign period_prod = 18'(period_s1) * 18'(PAUSE_SPAN);
	assign quot_est    = period_prod[17:10];
	assign rem_est     = 11'(period_prod[9:0]) + 11'(quot_est);
	assign pause_len   = PAUSE_W'(PAUSE_BASE) + quot_est
		+ PAUSE_W'(rem_est >= 11'(POT_FULL));

	assign step_inc   = step_count_q + STEP_W'(1);
	assign next_index = {1'b0, wave_index_q} + (IDX_W+1)'(1);
	assign pause_inc  = pause_count_q + PAUSE_W'(1);

	// state update for one tick
	always_comb begin
		wave_index_d  = wave_index_q;
		pause_flag_d  = pause_flag_q;
		step_count_d  = step_count_q;
		pause_count_d = pause_count_q;
		held_bright_d = held_bright_q;
		held_duty_d   = held_duty_q;
		if (!pause_flag_q) begin
			step_count_d = step_inc;
			if (step_inc >= divider) begin
				step_count_d = '0;
				if (next_index >= (IDX_W+1)'(WAVE_LEN)) begin
					// end of beat: go quiet
					wave_index_d  = '0;
					pause_flag_d  = 1'b1;
					pause_count_d = '0;
					held_bright_d = '0;
					held_duty_d   = '0;
				end else begin
					wave_index_d  = next_index[IDX_W-1:0];
					held_bright_d = wave_entry(next_index[IDX_W-1:0]);
					held_duty_d   = DUTY_LUT[next_index[IDX_W-1:0]];
				end
			end
		end else begin
			pause_count_d = pause_inc;
			if (pause_inc >= pause_len) begin
				pause_flag_d = 1'b0;
				wave_index_d = '0;
				step_count_d = '0;
			end
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave_index_q  <= '0;
			pause_flag_q  <= 1'b0;
			step_count_q  <= '0;
			pause_count_q <= '0;
			held_bright_q <= '0;
			held_duty_q   <= '0;
		end else if (advance) begin
			wave_index_q  <= wave_index_d;
			pause_flag_q  <= pause_flag_d;
			step_count_q  <= step_count_d;
			pause_count_q <= pause_count_d;
			held_bright_q <= held_bright_d;
			held_duty_q   <= held_duty_d;
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || led.ready) begin
			out_valid_q <= valid_s1;
		end
	end

	// result payload mirrors the held state
	assign led.valid      = out_valid_q;
	assign led.duty       = held_duty_q;
	assign led.brightness = held_bright_q;
	assign led.pausing    = pause_flag_q;

endmodule

### sv/hps_checker.sv
// Port-level checks for the heartbeat PWM pattern sequencer, bound to the top level.
module hps_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          led_valid,
	input logic                          led_ready,
	input logic [hps_pkg::DUTY_W-1:0]    led_duty,
	input logic [hps_pkg::BRIGHT_W-1:0]  led_brightness,
	input logic                          led_pausing
);
	import hps_pkg::*;

	// a pending led beat is not withdrawn
	a_led_hold: assert property (@(posedge clk) disable iff (!arst_n)
		led_valid && !led_ready |=> led_valid)
		else $error("led beat dropped while stalled");

	// a stalled led beat keeps its payload
	a_led_stable: assert property (@(posedge clk) disable iff (!arst_n)
		led_valid && !led_ready |=> $stable(led_duty) && $stable(led_brightness)
			&& $stable(led_pausing))
		else $error("led payload changed while stalled");

	// the LED is dark throughout the pause
	a_dark_pause: assert property (@(posedge clk) disable iff (!arst_n)
		led_valid && led_pausing |-> led_brightness == '0 && led_duty == '0)
		else $error("LED lit during pause");

	// zero brightness always drives zero duty
	a_zero_duty: assert property (@(posedge clk) disable iff (!arst_n)
		led_valid && led_brightness == '0 |-> led_duty == '0)
		else $error("duty non-zero at zero brightness");

endmodule

bind heartbeat_pwm_pattern_sequencer hps_checker u_hps_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.led_valid      (led.valid),
	.led_ready      (led.ready),
	.led_duty       (led.duty),
	.led_brightness (led.brightness),
	.led_pausing    (led.pausing)
);
